@@ rtl/vlan_tag_parse_filter_top_macros.svh @@
// ----------------------------------------------------------------------------
// vlan tag parse filter assertion macros
// concurrent assertion shorthands clocked on clk, used by the port checker
// ----------------------------------------------------------------------------
`ifndef VLAN_TAG_PARSE_FILTER_TOP_MACROS_SVH
`define VLAN_TAG_PARSE_FILTER_TOP_MACROS_SVH

// property checked only outside reset
`define VTPF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// property checked at every edge, reset included
`define VTPF_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

@@ rtl/vtpf_pkg.sv @@
// ----------------------------------------------------------------------------
// vtpf_pkg
// shared types, constants and helpers of the vlan tag parser and filter
// ----------------------------------------------------------------------------
`default_nettype none

package vtpf_pkg;

	localparam int unsigned IDX_W     = 5;
	localparam int unsigned VID_W     = 12;
	localparam int unsigned ETYPE_W   = 16;
	localparam int unsigned CFG_W     = 16;
	localparam int unsigned CFG_IDX_W = 1;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_DROP_VID   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PASS_ETYPE = 1'd1;

	localparam logic [VID_W-1:0]   DROP_VID_RST   = 12'd4011;
	localparam logic [ETYPE_W-1:0] PASS_ETYPE_RST = 16'h0806;

	localparam logic [ETYPE_W-1:0] TPID_CTAG = 16'h8100;
	localparam logic [ETYPE_W-1:0] TPID_STAG = 16'h88A8;

	// byte positions inside the frame header
	localparam logic [IDX_W-1:0] POS_TYPE_HI  = 5'd12;
	localparam logic [IDX_W-1:0] POS_TYPE_LO  = 5'd13;
	localparam logic [IDX_W-1:0] POS_OTCI_HI  = 5'd14;
	localparam logic [IDX_W-1:0] POS_OTCI_LO  = 5'd15;
	localparam logic [IDX_W-1:0] POS_OTYPE_HI = 5'd16;
	localparam logic [IDX_W-1:0] POS_OTYPE_LO = 5'd17;
	localparam logic [IDX_W-1:0] POS_ITCI_HI  = 5'd18;
	localparam logic [IDX_W-1:0] POS_ITCI_LO  = 5'd19;
	localparam logic [IDX_W-1:0] POS_ITYPE_HI = 5'd20;
	localparam logic [IDX_W-1:0] POS_ITYPE_LO = 5'd21;
	localparam logic [IDX_W-1:0] IDX_MAX      = 5'd31;
	localparam logic [IDX_W-1:0] MIN_FRAME    = 5'd22;

	localparam logic [4:0] L3_BASE = 5'd14;
	localparam logic [4:0] TAG_LEN = 5'd4;

	// summary queue between front and back
	localparam int unsigned Q_DEPTH = 2;
	localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} vtpf_in_t;

	typedef struct packed {
		logic               verdict;
		logic               too_short;
		logic [VID_W-1:0]   outer_vid;
		logic [VID_W-1:0]   inner_vid;
		logic [ETYPE_W-1:0] l3_type;
		logic [4:0]         l3_start;
	} vtpf_out_t;

	// per-frame summary from the parser
	typedef struct packed {
		logic               too_short;
		logic [VID_W-1:0]   outer_vid;
		logic [VID_W-1:0]   inner_vid;
		logic [ETYPE_W-1:0] l3_type;
		logic [4:0]         l3_start;
	} vtpf_sum_t;

	typedef struct packed {
		logic full;
		logic empty;
	} vtpf_qstat_t;

	function automatic logic is_tpid(input logic [ETYPE_W-1:0] t);
		return (t == TPID_CTAG) || (t == TPID_STAG);
	endfunction

endpackage

`default_nettype wire

@@ rtl/vlan_tag_parse_filter_top.sv @@
// ----------------------------------------------------------------------------
// vlan_tag_parse_filter_top
// single and double vlan tag parser with a per-frame pass/drop verdict
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready/in_data): one frame byte per item, in wire
//   order, with last_byte set on the final byte of each frame
//   output channel (out_valid/out_ready/out_data): one verdict item per frame,
//   carrying drop flag, short flag, outer and inner vid, l3 ethertype and offset
//   config port: cfg_we/cfg_index/cfg_wdata, index 0 is drop_vid, index 1 is
//   pass_ethertype; write only while no frame is in flight
// timing
//   one byte per cycle sustained; in_ready drops only while the two-entry
//   summary queue is full, which happens only if the receiver stalls
//   out_valid rises when the summary moves from the queue to the output register
// reset
//   arst_n clears the parser, the queue and out_valid, and loads drop_vid 4011
//   and pass_ethertype 0x0806
// stall
//   a held verdict stays stable in the output register while bytes keep
//   flowing; up to two further frame summaries queue behind it
// ----------------------------------------------------------------------------
`default_nettype none

module vlan_tag_parse_filter_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  vtpf_pkg::vtpf_in_t                 in_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output vtpf_pkg::vtpf_out_t                out_data,
	input  wire logic                          cfg_we,
	input  wire logic [vtpf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [vtpf_pkg::CFG_W-1:0]    cfg_wdata
);
	import vtpf_pkg::*;

	logic        in_accept;
	logic        sum_push;
	vtpf_sum_t   sum_data;
	logic        q_pop;
	vtpf_sum_t   q_data;
	vtpf_qstat_t q_stat;

	// byte flow halts whenever the summary queue is full
	assign in_ready  = !q_stat.full;
	assign in_accept = in_valid && in_ready;

	// front: header walk, one byte per cycle unless a full summary queue holds the input
	vtpf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (in_accept),
		.item     (in_data),
		.sum_push (sum_push),
		.sum_data (sum_data)
	);

	// decoupling queue of per-frame summaries
	vtpf_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (sum_push),
		.push_data (sum_data),
		.pop       (q_pop),
		.pop_data  (q_data),
		.stat      (q_stat)
	);

	// back: filter decision and output register
	vtpf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.q_stat    (q_stat),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

@@ rtl/vtpf_fifo.sv @@
// ----------------------------------------------------------------------------
// vtpf_fifo
// short register queue of frame summaries between parser and verdict stage
// ----------------------------------------------------------------------------
`default_nettype none

module vtpf_fifo (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  vtpf_pkg::vtpf_sum_t      push_data,
	input  wire logic                pop,
	output vtpf_pkg::vtpf_sum_t      pop_data,
	output vtpf_pkg::vtpf_qstat_t    stat
);
	import vtpf_pkg::*;

	vtpf_sum_t            mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;
	logic                 do_push;
	logic                 do_pop;

	localparam logic [Q_PTR_W-1:0] PTR_LAST = Q_PTR_W'(Q_DEPTH - 1);
	localparam logic [Q_CNT_W-1:0] CNT_FULL = Q_CNT_W'(Q_DEPTH);

	assign stat.full  = (count_q == CNT_FULL);
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/vtpf_front.sv @@
// ----------------------------------------------------------------------------
// vtpf_front
// byte parser: walks the header, captures tags and ethertype, emits a summary
// ----------------------------------------------------------------------------
`default_nettype none

module vtpf_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  vtpf_pkg::vtpf_in_t    item,
	output logic                  sum_push,
	output vtpf_pkg::vtpf_sum_t   sum_data
);
	import vtpf_pkg::*;

	logic [IDX_W-1:0]   byte_index_q, byte_index_n;
	logic [ETYPE_W-1:0] type_hold_q, type_hold_n;
	logic [7:0]         tci_high_q, tci_high_n;
	logic               outer_seen_q, outer_seen_n;
	logic               inner_seen_q, inner_seen_n;
	logic [VID_W-1:0]   outer_id_q, outer_id_n;
	logic [VID_W-1:0]   inner_id_q, inner_id_n;
	logic [ETYPE_W-1:0] type_lo;
	logic               short_frame;

	assign type_lo = {type_hold_q[15:8], item.frame_byte};

	always_comb begin
		type_hold_n  = type_hold_q;
		tci_high_n   = tci_high_q;
		outer_seen_n = outer_seen_q;
		inner_seen_n = inner_seen_q;
		outer_id_n   = outer_id_q;
		inner_id_n   = inner_id_q;
		unique case (byte_index_q)
			POS_TYPE_HI: begin
				type_hold_n = {item.frame_byte, 8'h00};
			end
			POS_TYPE_LO: begin
				type_hold_n  = type_lo;
				outer_seen_n = is_tpid(type_lo);
			end
			POS_OTCI_HI: begin
				if (outer_seen_q) tci_high_n = item.frame_byte;
			end
			POS_OTCI_LO: begin
				if (outer_seen_q) outer_id_n = {tci_high_q[3:0], item.frame_byte};
			end
			POS_OTYPE_HI: begin
				if (outer_seen_q) type_hold_n = {item.frame_byte, 8'h00};
			end
			POS_OTYPE_LO: begin
				if (outer_seen_q) begin
					type_hold_n  = type_lo;
					inner_seen_n = is_tpid(type_lo);
				end
			end
			POS_ITCI_HI: begin
				if (inner_seen_q) tci_high_n = item.frame_byte;
			end
			POS_ITCI_LO: begin
				if (inner_seen_q) inner_id_n = {tci_high_q[3:0], item.frame_byte};
			end
			POS_ITYPE_HI: begin
				if (inner_seen_q) type_hold_n = {item.frame_byte, 8'h00};
			end
			POS_ITYPE_LO: begin
				if (inner_seen_q) type_hold_n = type_lo;
			end
			default: begin
			end
		endcase
	end

	assign byte_index_n = (byte_index_q == IDX_MAX) ? byte_index_q : byte_index_q + 1'b1;

	// frame shorter than the full double-tag header
	assign short_frame = (byte_index_q < (MIN_FRAME - 1'b1));

	assign sum_push = accept && item.last_byte;

	always_comb begin
		sum_data = '0;
		sum_data.too_short = short_frame;
		if (!short_frame) begin
			sum_data.outer_vid = outer_id_n;
			sum_data.inner_vid = inner_id_n;
			sum_data.l3_type   = type_hold_n;
			sum_data.l3_start  = L3_BASE + (outer_seen_n ? TAG_LEN : 5'd0)
				+ (inner_seen_n ? TAG_LEN : 5'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0;
			type_hold_q  <= '0;
			tci_high_q   <= '0;
			outer_seen_q <= 1'b0;
			inner_seen_q <= 1'b0;
			outer_id_q   <= '0;
			inner_id_q   <= '0;
		end else if (accept) begin
			if (item.last_byte) begin
				byte_index_q <= '0;
				type_hold_q  <= '0;
				tci_high_q   <= '0;
				outer_seen_q <= 1'b0;
				inner_seen_q <= 1'b0;
				outer_id_q   <= '0;
				inner_id_q   <= '0;
			end else begin
				byte_index_q <= byte_index_n;
				type_hold_q  <= type_hold_n;
				tci_high_q   <= tci_high_n;
				outer_seen_q <= outer_seen_n;
				inner_seen_q <= inner_seen_n;
				outer_id_q   <= outer_id_n;
				inner_id_q   <= inner_id_n;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/vtpf_back.sv @@
// ----------------------------------------------------------------------------
// vtpf_back
// verdict stage: filter registers, drop decision and output register
// ----------------------------------------------------------------------------
`default_nettype none

module vtpf_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [vtpf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [vtpf_pkg::CFG_W-1:0]    cfg_wdata,
	input  vtpf_pkg::vtpf_qstat_t              q_stat,
	input  vtpf_pkg::vtpf_sum_t                q_data,
	output logic                               q_pop,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output vtpf_pkg::vtpf_out_t                out_data
);
	import vtpf_pkg::*;

	logic [VID_W-1:0]   drop_vid_q;
	logic [ETYPE_W-1:0] pass_etype_q;
	logic               out_valid_q;
	vtpf_out_t          out_data_q;
	vtpf_out_t          result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_vid_q   <= DROP_VID_RST;
			pass_etype_q <= PASS_ETYPE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DROP_VID:   drop_vid_q   <= cfg_wdata[VID_W-1:0];
				CFG_PASS_ETYPE: pass_etype_q <= cfg_wdata[ETYPE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		result.too_short = q_data.too_short;
		result.outer_vid = q_data.outer_vid;
		result.inner_vid = q_data.inner_vid;
		result.l3_type   = q_data.l3_type;
		result.l3_start  = q_data.l3_start;
		if (q_data.too_short) begin
			result.verdict = 1'b1;
		end else if (q_data.l3_type == pass_etype_q) begin
			result.verdict = 1'b0;
		end else begin
			result.verdict = (q_data.outer_vid == drop_vid_q);
		end
	end

	assign q_pop = !q_stat.empty && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

@@ rtl/vtpf_checker.sv @@
// ----------------------------------------------------------------------------
// vtpf_checker
// port-level checks of the vlan tag parser, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "vlan_tag_parse_filter_top_macros.svh"

module vtpf_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          out_valid,
	input  wire logic                          out_ready,
	input  vtpf_pkg::vtpf_out_t                out_data
);
	import vtpf_pkg::*;

	// a stalled verdict holds
	`VTPF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "verdict changed while stalled")

	// short frames are dropped with all header fields cleared
	`VTPF_ASSERT(a_short_drop, out_valid && out_data.too_short |-> out_data.verdict && out_data.outer_vid == '0 && out_data.inner_vid == '0 && out_data.l3_type == '0 && out_data.l3_start == '0, "short frame verdict malformed")

	// full frames report one of the three layer-3 offsets
	`VTPF_ASSERT(a_l3_start, out_valid && !out_data.too_short |-> out_data.l3_start == 5'd14 || out_data.l3_start == 5'd18 || out_data.l3_start == 5'd22, "bad layer-3 offset")

	// an inner vid only comes with a second tag
	`VTPF_ASSERT(a_inner_tag, out_valid && out_data.inner_vid != '0 |-> out_data.l3_start == 5'd22, "inner vid without inner tag")

	// reset seen at an edge clears any offered verdict
	`VTPF_ASSERT_ALWAYS(a_rst_quiet, !arst_n |=> !out_valid, "verdict offered during reset")

endmodule

bind vlan_tag_parse_filter_top vtpf_checker u_vtpf_checker (.*);

`default_nettype wire

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// self-checking regression of vlan_tag_parse_filter_top: frames go in one byte
// per item, a behavioral model of the tag parser predicts one verdict per frame,
// and every verdict item that leaves the block is compared with it field by field
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import vtpf_pkg::*;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int SETTLE_CYCLES = 6;
	localparam int RANDOM_BYTES  = 160;
	localparam int STEADY_BYTES  = 60;

	localparam logic [ETYPE_W-1:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [ETYPE_W-1:0] ETYPE_ARP  = 16'h0806;

	// clock, reset and block ports; the driven ones are known from time zero
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	vtpf_in_t             in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	vtpf_out_t            out_data;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_DROP_VID;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	// register mirror, loaded with the reset values of the block
	logic [VID_W-1:0]   drop_vid_cfg   = DROP_VID_RST;
	logic [ETYPE_W-1:0] pass_etype_cfg = PASS_ETYPE_RST;

	// per-frame parser state of the model
	logic [IDX_W-1:0]   hdr_pos       = '0;
	logic [ETYPE_W-1:0] etype_acc     = '0;
	logic [7:0]         tci_hi        = '0;
	logic               outer_tag     = 1'b0;
	logic               inner_tag     = 1'b0;
	logic [VID_W-1:0]   outer_vid_acc = '0;
	logic [VID_W-1:0]   inner_vid_acc = '0;

	vtpf_out_t  pending_verdicts[$];
	logic [7:0] frame_buf[$];

	int errors      = 0;
	int cycle_count = 0;
	int bytes_sent  = 0;
	int idle_pct    = 0;
	int stall_left  = 0;

	vlan_tag_parse_filter_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// run limit, covers a stuck handshake or a verdict that never comes
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d verdicts still expected", $time,
				pending_verdicts.size());
			$display("vlan_tag_parse_filter_top regression: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// model of the parser: one call per accepted byte
	// ------------------------------------------------------------------------
	task automatic parse_byte(input vtpf_in_t item);
		logic [IDX_W-1:0]   at;
		logic [7:0]         b;
		logic [ETYPE_W-1:0] l3;
		vtpf_out_t          v;
		at = hdr_pos;
		b  = item.frame_byte;
		case (at)
			POS_TYPE_HI: etype_acc = {b, 8'h00};
			POS_TYPE_LO: begin
				etype_acc[7:0] = b;
				outer_tag = (etype_acc == TPID_CTAG) || (etype_acc == TPID_STAG);
			end
			POS_OTCI_HI: if (outer_tag) tci_hi = b;
			POS_OTCI_LO: if (outer_tag) outer_vid_acc = {tci_hi[3:0], b};
			POS_OTYPE_HI: if (outer_tag) etype_acc = {b, 8'h00};
			POS_OTYPE_LO: if (outer_tag) begin
				etype_acc[7:0] = b;
				inner_tag = (etype_acc == TPID_CTAG) || (etype_acc == TPID_STAG);
			end
			POS_ITCI_HI: if (inner_tag) tci_hi = b;
			POS_ITCI_LO: if (inner_tag) inner_vid_acc = {tci_hi[3:0], b};
			POS_ITYPE_HI: if (inner_tag) etype_acc = {b, 8'h00};
			POS_ITYPE_LO: if (inner_tag) etype_acc[7:0] = b;
			default: ;
		endcase
		// past the header the position only counts up to saturation
		if (hdr_pos != IDX_MAX)
			hdr_pos = hdr_pos + 1'b1;
		if (item.last_byte) begin
			v = '0;
			if (int'(at) + 1 < int'(MIN_FRAME)) begin
				// short frame: dropped, all other fields zero
				v.verdict   = 1'b1;
				v.too_short = 1'b1;
			end else begin
				l3 = etype_acc;
				v.outer_vid = outer_vid_acc;
				v.inner_vid = inner_vid_acc;
				v.l3_type   = l3;
				v.l3_start  = L3_BASE + (outer_tag ? TAG_LEN : 5'd0)
					+ (inner_tag ? TAG_LEN : 5'd0);
				// pass ethertype wins over the drop vid
				if (l3 == pass_etype_cfg)
					v.verdict = 1'b0;
				else
					v.verdict = (outer_vid_acc == drop_vid_cfg);
			end
			pending_verdicts.push_back(v);
			hdr_pos       = '0;
			etype_acc     = '0;
			tci_hi        = '0;
			outer_tag     = 1'b0;
			inner_tag     = 1'b0;
			outer_vid_acc = '0;
			inner_vid_acc = '0;
		end
	endtask

	task automatic compare_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic check_verdict(input vtpf_out_t got);
		vtpf_out_t want;
		if (pending_verdicts.size() == 0) begin
			$display("%0t: verdict item with none expected, expected none got %h",
				$time, got);
			errors++;
		end else begin
			want = pending_verdicts.pop_front();
			compare_field("verdict", want.verdict, got.verdict);
			compare_field("too_short", want.too_short, got.too_short);
			compare_field("outer_vid", want.outer_vid, got.outer_vid);
			compare_field("inner_vid", want.inner_vid, got.inner_vid);
			compare_field("l3_type", want.l3_type, got.l3_type);
			compare_field("l3_start", want.l3_start, got.l3_start);
		end
	endtask

	// sampled at the rising edge, before the block's registers move
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_DROP_VID:   drop_vid_cfg   = cfg_wdata[VID_W-1:0];
					CFG_PASS_ETYPE: pass_etype_cfg = cfg_wdata[ETYPE_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				parse_byte(in_data);
			if (out_valid && out_ready)
				check_verdict(out_data);
		end
	end

	// receiver: random stall bursts while idling is on
	initial begin
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				stall_left = $urandom_range(0, 6);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers, all entered and left at a falling edge
	// ------------------------------------------------------------------------

	// one byte item; valid stays high after acceptance until the caller moves on
	task automatic send_byte(input logic [7:0] b, input logic last);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{frame_byte: b, last_byte: last};
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		bytes_sent++;
	endtask

	// drop valid, wait for every verdict, then let the pipeline run empty
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// both registers, back to back, only while the block is idle
	task automatic configure(input logic [CFG_W-1:0] drop_word,
		input logic [CFG_W-1:0] pass_word);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_DROP_VID;
		cfg_wdata <= drop_word;
		@(negedge clk);
		cfg_index <= CFG_PASS_ETYPE;
		cfg_wdata <= pass_word;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// random macs, up to two tags with random pcp/dei, then the l3 type and payload;
	// the frame is cut at len whether the header is complete or not
	task automatic build_frame(input int len, input int tags,
		input logic [15:0] tpid_a, input logic [11:0] vid_a,
		input logic [15:0] tpid_b, input logic [11:0] vid_b, input logic [15:0] l3);
		logic [7:0] hdr[$];
		int k;
		hdr = {};
		for (k = 0; k < 12; k++)
			hdr.push_back(8'($urandom_range(0, 255)));
		if (tags > 0) begin
			hdr.push_back(tpid_a[15:8]);
			hdr.push_back(tpid_a[7:0]);
			hdr.push_back({4'($urandom_range(0, 15)), vid_a[11:8]});
			hdr.push_back(vid_a[7:0]);
		end
		if (tags > 1) begin
			hdr.push_back(tpid_b[15:8]);
			hdr.push_back(tpid_b[7:0]);
			hdr.push_back({4'($urandom_range(0, 15)), vid_b[11:8]});
			hdr.push_back(vid_b[7:0]);
		end
		hdr.push_back(l3[15:8]);
		hdr.push_back(l3[7:0]);
		frame_buf = {};
		for (k = 0; k < len; k++)
			frame_buf.push_back(k < hdr.size() ? hdr[k] : 8'($urandom_range(0, 255)));
	endtask

	task automatic push_frame(input int len, input int tags,
		input logic [15:0] tpid_a, input logic [11:0] vid_a,
		input logic [15:0] tpid_b, input logic [11:0] vid_b, input logic [15:0] l3);
		int k;
		build_frame(len, tags, tpid_a, vid_a, tpid_b, vid_b, l3);
		for (k = 0; k < frame_buf.size(); k++)
			send_byte(frame_buf[k], k == frame_buf.size() - 1);
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// reset values: drop vid 4011, pass ethertype arp
	task automatic test_reset_registers();
		push_frame(22, 0, TPID_CTAG, 12'd0, TPID_CTAG, 12'd0, ETYPE_IPV4);
		push_frame(22, 1, TPID_CTAG, DROP_VID_RST, TPID_CTAG, 12'd0, ETYPE_IPV4);
		push_frame(22, 1, TPID_STAG, DROP_VID_RST, TPID_CTAG, 12'd0, ETYPE_ARP);
		push_frame(22, 2, TPID_STAG, DROP_VID_RST, TPID_CTAG, 12'd7, ETYPE_IPV4);
		push_frame(23, 2, TPID_STAG, 12'd5, TPID_CTAG, DROP_VID_RST, ETYPE_IPV4);
	endtask

	// frames below the minimum are dropped and flagged, 22 bytes is not short
	task automatic test_short_frames();
		push_frame(1, 0, TPID_CTAG, 12'd0, TPID_CTAG, 12'd0, ETYPE_ARP);
		push_frame(13, 0, TPID_CTAG, 12'd0, TPID_CTAG, 12'd0, ETYPE_ARP);
		push_frame(21, 0, TPID_CTAG, 12'd0, TPID_CTAG, 12'd0, ETYPE_ARP);
		push_frame(18, 1, TPID_CTAG, 12'd3, TPID_CTAG, 12'd0, ETYPE_IPV4);
		push_frame(21, 2, TPID_STAG, 12'd9, TPID_CTAG, 12'd4, ETYPE_IPV4);
		push_frame(22, 0, TPID_CTAG, 12'd0, TPID_CTAG, 12'd0, ETYPE_IPV4);
	endtask

	// both tpids in both positions, near misses, vid and ethertype extremes
	task automatic test_tag_formats();
		push_frame(22, 1, TPID_STAG, 12'd0, TPID_CTAG, 12'd0, ETYPE_IPV4);
		push_frame(22, 1, TPID_CTAG, 12'hfff, TPID_CTAG, 12'd0, 16'hffff);
		push_frame(22, 2, TPID_STAG, 12'hfff, TPID_CTAG, 12'hfff, 16'h0000);
		push_frame(24, 2, TPID_CTAG, 12'd1, TPID_STAG, 12'h800, ETYPE_IPV4);
		push_frame(22, 1, 16'h8101, 12'h123, TPID_CTAG, 12'd0, ETYPE_IPV4);
		push_frame(22, 1, 16'h88a9, 12'h456, TPID_CTAG, 12'd0, ETYPE_IPV4);
		// tag-like type behind a plain ethertype is payload
		push_frame(22, 2, ETYPE_IPV4, 12'h321, TPID_CTAG, 12'h654, ETYPE_IPV4);
		// inner near miss ends the tag chain after one tag
		push_frame(22, 2, TPID_CTAG, 12'h0aa, 16'h8000, 12'h055, ETYPE_IPV4);
	endtask

	// long frames run the byte position into saturation
	task automatic test_long_frames();
		push_frame(32, 0, TPID_CTAG, 12'd0, TPID_CTAG, 12'd0, ETYPE_IPV4);
		push_frame(64, 2, TPID_STAG, DROP_VID_RST, TPID_CTAG, 12'd2, ETYPE_IPV4);
		push_frame(150, 1, TPID_CTAG, 12'd77, TPID_CTAG, 12'd0, ETYPE_ARP);
	endtask

	// drop vid zero catches untagged frames unless the ethertype is passed
	task automatic test_drop_vid_zero();
		configure(16'h0000, 16'hffff);
		push_frame(22, 0, TPID_CTAG, 12'd0, TPID_CTAG, 12'd0, ETYPE_IPV4);
		push_frame(22, 0, TPID_CTAG, 12'd0, TPID_CTAG, 12'd0, 16'hffff);
		push_frame(22, 1, TPID_CTAG, 12'd0, TPID_CTAG, 12'd0, ETYPE_ARP);
		push_frame(22, 1, TPID_CTAG, 12'd1, TPID_CTAG, 12'd0, ETYPE_ARP);
		push_frame(5, 0, TPID_CTAG, 12'd0, TPID_CTAG, 12'd0, 16'hffff);
	endtask

	// all-ones and all-zeros register values, upper write bits ignored
	task automatic test_register_extremes();
		configure(16'hffff, 16'h0000);
		push_frame(22, 1, TPID_STAG, 12'hfff, TPID_CTAG, 12'd0, ETYPE_IPV4);
		push_frame(22, 1, TPID_STAG, 12'hfff, TPID_CTAG, 12'd0, 16'h0000);
		configure(16'ha123, TPID_CTAG);
		push_frame(22, 1, TPID_CTAG, 12'h123, TPID_CTAG, 12'd0, ETYPE_IPV4);
		// a third tag leaves a tpid as the l3 type, which is the pass ethertype here
		push_frame(26, 2, TPID_STAG, 12'h123, TPID_CTAG, 12'd8, TPID_CTAG);
	endtask

	task automatic random_registers();
		logic [15:0] drop_word;
		logic [15:0] pass_word;
		drop_word = 16'($urandom);
		pass_word = 16'($urandom);
		case ($urandom_range(0, 3))
			0: drop_word[11:0] = 12'h000;
			1: drop_word[11:0] = 12'hfff;
			default: ;
		endcase
		case ($urandom_range(0, 4))
			0: pass_word = 16'h0000;
			1: pass_word = 16'hffff;
			2: pass_word = ETYPE_IPV4;
			default: ;
		endcase
		configure(drop_word, pass_word);
	endtask

	// mostly well-formed tagged frames, some near-miss noise, some short bursts
	task automatic random_frame();
		int sel;
		int len;
		int tags;
		int k;
		logic [15:0] tpid_a;
		logic [15:0] tpid_b;
		logic [15:0] l3;
		logic [11:0] vid_a;
		logic [11:0] vid_b;
		sel    = $urandom_range(0, 99);
		tags   = $urandom_range(0, 2);
		tpid_a = $urandom_range(0, 1) ? TPID_CTAG : TPID_STAG;
		tpid_b = $urandom_range(0, 1) ? TPID_CTAG : TPID_STAG;
		vid_a  = ($urandom_range(0, 2) == 0) ? drop_vid_cfg : 12'($urandom);
		vid_b  = ($urandom_range(0, 3) == 0) ? drop_vid_cfg : 12'($urandom);
		case ($urandom_range(0, 3))
			0: l3 = pass_etype_cfg;
			1: l3 = ETYPE_IPV4;
			default: l3 = 16'($urandom);
		endcase
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 90) : $urandom_range(22, 40);
		if (sel < 6) begin
			// burst of tiny frames to fill the verdict queue
			repeat ($urandom_range(4, 8))
				push_frame($urandom_range(1, 3), 0, tpid_a, vid_a, tpid_b, vid_b, l3);
		end else if (sel < 16) begin
			push_frame($urandom_range(1, 21), tags, tpid_a, vid_a, tpid_b, vid_b, l3);
		end else if (sel < 26) begin
			// flip one bit of a tpid, or use random bytes
			k = $urandom_range(0, 2);
			if (k == 0)
				tpid_a = tpid_a ^ (16'h1 << $urandom_range(0, 15));
			else if (k == 1)
				tpid_b = tpid_b ^ (16'h1 << $urandom_range(0, 15));
			else
				tpid_a = 16'($urandom);
			push_frame(len, 2, tpid_a, vid_a, tpid_b, vid_b, l3);
		end else begin
			push_frame(len, tags, tpid_a, vid_a, tpid_b, vid_b, l3);
		end
	endtask

	task automatic test_random_traffic();
		int stop_at;
		int cfg_due;
		stop_at = bytes_sent + RANDOM_BYTES;
		cfg_due = $urandom_range(5, 10);
		while (bytes_sent < stop_at) begin
			// some frames with no idling at all, others with varied pressure
			idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
			random_frame();
			cfg_due--;
			if (cfg_due == 0) begin
				random_registers();
				cfg_due = $urandom_range(5, 10);
			end
		end
	endtask

	// last stretch at full rate on both sides
	task automatic test_steady_stream();
		int stop_at;
		settle();
		idle_pct = 0;
		stop_at  = bytes_sent + STEADY_BYTES;
		while (bytes_sent < stop_at)
			random_frame();
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		idle_pct = 25;
		test_reset_registers();
		test_short_frames();
		test_tag_formats();
		test_long_frames();
		test_drop_vid_zero();
		test_register_extremes();
		test_random_traffic();
		test_steady_stream();
		// drain, then watch a little longer for stray verdict items
		settle();
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("vlan_tag_parse_filter_top regression: pass");
		else
			$display("vlan_tag_parse_filter_top regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
